// ----- hw/rtl/imhq_pkg.sv -----
// ---------------------------------------------------------------------------
// imhq_pkg: shared types and constants of the indexed min-heap queue
// Holds the operation and status codes, widths and the sequencer state type.
// ---------------------------------------------------------------------------
package imhq_pkg;

   localparam int SymbolCount = 256;
   localparam int PriorityBits = 32;
   localparam int SymBits = $clog2(SymbolCount);
   localparam int CountBits = $clog2(SymbolCount + 1);

   typedef logic [SymBits-1:0] sym_type;
   typedef logic signed [PriorityBits-1:0] prio_type;
   typedef logic [CountBits-1:0] count_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_CHANGE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_PRESENT = 2'd1,
      ST_ABSENT  = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_LOOKUP,
      S_CHGRD,
      S_POPRD,
      S_UPRD,
      S_UPCMP,
      S_DNRD,
      S_DNRD2,
      S_DNCMP,
      S_ROOTRD,
      S_ROOTWT,
      S_RESULT
   } state_type;

endpackage

// ----- hw/rtl/imhq_sym_table.sv -----
// ---------------------------------------------------------------------------
// imhq_sym_table: symbol-to-position table with present bits
// Position memory with registered read; present bits in flip-flops.
// ---------------------------------------------------------------------------
module imhq_sym_table
   import imhq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  sym_type rd_sym,
   output sym_type rd_pos,
   input  logic    pos_we,
   input  sym_type pos_sym,
   input  sym_type pos_val,
   input  logic    pres_we,
   input  sym_type pres_sym,
   input  logic    pres_val,
   input  sym_type chk_sym,
   output logic    chk_present
);

   sym_type pos_mem [SymbolCount];
   sym_type rd_pos_ff;
   logic [SymbolCount-1:0] present_ff;

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_sym] <= pos_val;
      end
      rd_pos_ff <= pos_mem[rd_sym];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else if (pres_we) begin
         present_ff[pres_sym] <= pres_val;
      end
   end

   assign rd_pos = rd_pos_ff;
   assign chk_present = present_ff[chk_sym];

endmodule

// ----- hw/rtl/indexed_min_heap_queue_unit.sv -----
// ---------------------------------------------------------------------------
// indexed_min_heap_queue_unit: indexed binary min-heap of distinct symbols
// Insert, pop-minimum and change-priority over a heap held in memories.
// ---------------------------------------------------------------------------
// One request is taken at a time. req_tready is low while it is worked on and
// while its response waits in the output register.
// A request goes through decode; a change then looks up the symbol's position,
// and a pop of more than one symbol moves the last node to the root. A sift
// then walks the heap level by level, up or down, for as long as the moving
// node must move. Finally the moving node is written at its final spot, the
// root is read back and the response is registered. The single heap memory
// port does one read and one write each cycle.
module indexed_min_heap_queue_unit
   import imhq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // op[1:0], symbol[9:2], priority_req[41:10], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // status[1:0], min_symbol[9:2], min_priority[41:10],
                                   // count[50:42], is_empty[51], zero fill
);

   sym_type  hs_mem [SymbolCount];
   prio_type hp_mem [SymbolCount];

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   sym_type   sym_ff, sym_in;
   prio_type  pr_ff, pr_in;
   count_type cnt_ff, cnt_in;
   count_type idx_ff, idx_in;      // current node
   sym_type   cs_ff, cs_in;        // symbol moving through the heap
   prio_type  cp_ff, cp_in;        // its priority
   sym_type   as_ff, as_in;        // first read symbol
   prio_type  ap_ff, ap_in;        // first read priority
   status_type st_ff, st_in;
   logic      vld_ff, vld_in;
   logic [55:0] out_ff, out_in;

   // heap memory port
   logic     hw_we;
   sym_type  hw_addr, hr_addr;
   sym_type  hw_sym, hr_sym_ff;
   prio_type hw_pr, hr_pr_ff;

   always_ff @(posedge clock) begin
      if (hw_we) begin
         hs_mem[hw_addr] <= hw_sym;
         hp_mem[hw_addr] <= hw_pr;
      end
      hr_sym_ff <= hs_mem[hr_addr];
      hr_pr_ff  <= hp_mem[hr_addr];
   end

   // symbol table
   sym_type t_rd_sym, t_rd_pos, t_pos_sym, t_pos_val, t_pres_sym, t_chk_sym;
   logic    t_pos_we, t_pres_we, t_pres_val, t_present;

   imhq_sym_table u_table (
      .clock       (clock),
      .reset       (reset),
      .rd_sym      (t_rd_sym),
      .rd_pos      (t_rd_pos),
      .pos_we      (t_pos_we),
      .pos_sym     (t_pos_sym),
      .pos_val     (t_pos_val),
      .pres_we     (t_pres_we),
      .pres_sym    (t_pres_sym),
      .pres_val    (t_pres_val),
      .chk_sym     (t_chk_sym),
      .chk_present (t_present)
   );

   count_type parent_idx, left_idx, right_idx;
   assign parent_idx = (idx_ff - count_type'(1)) >> 1;
   assign left_idx   = count_type'({idx_ff, 1'b1});
   assign right_idx  = left_idx + count_type'(1);

   // Child chosen by a sift down step; the right child wins ties.
   logic      dn_two, dn_left;
   sym_type   dn_sym;
   prio_type  dn_pr;
   count_type dn_idx;
   assign dn_two  = right_idx < cnt_ff;
   assign dn_left = dn_two && (ap_ff < hr_pr_ff);
   assign dn_sym  = dn_left ? as_ff : hr_sym_ff;
   assign dn_pr   = dn_left ? ap_ff : hr_pr_ff;
   assign dn_idx  = (dn_left || !dn_two) ? left_idx : right_idx;

   // shared comparator
   prio_type cmp_a, cmp_b;
   logic     cmp_lt;
   assign cmp_lt = cmp_a < cmp_b;

   always_comb begin
      if (state_ff == S_DNCMP) begin
         cmp_a = dn_pr;
         cmp_b = cp_ff;
      end else begin
         cmp_a = cp_ff;
         cmp_b = hr_pr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      sym_ff <= sym_in;
      pr_ff  <= pr_in;
      idx_ff <= idx_in;
      cs_ff  <= cs_in;
      cp_ff  <= cp_in;
      as_ff  <= as_in;
      ap_ff  <= ap_in;
      st_ff  <= st_in;
      out_ff <= out_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !vld_ff;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = out_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !vld_ff) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (op_ff)
               OP_INSERT: state_in = (t_present || cnt_ff >= count_type'(SymbolCount))
                                     ? S_ROOTRD : S_UPRD;
               OP_POP:    state_in = (cnt_ff == '0) ? S_ROOTRD :
                                     (cnt_ff == count_type'(1)) ? S_ROOTRD : S_POPRD;
               OP_CHANGE: state_in = t_present ? S_LOOKUP : S_ROOTRD;
               default:   state_in = S_ROOTRD;
            endcase
         end
         S_LOOKUP: state_in = S_CHGRD;
         S_CHGRD:  state_in = (hr_pr_ff < pr_ff) ? S_DNRD :
                              (hr_pr_ff > pr_ff) ? S_UPRD : S_ROOTRD;
         S_POPRD:  state_in = S_DNRD;
         S_UPRD:   state_in = (idx_ff == '0) ? S_ROOTRD : S_UPCMP;
         S_UPCMP:  state_in = cmp_lt ? S_UPRD : S_ROOTRD;
         S_DNRD: begin
            if (left_idx >= cnt_ff || idx_ff >= count_type'(SymbolCount / 2)) begin
               state_in = S_ROOTRD;
            end else begin
               state_in = (right_idx < cnt_ff) ? S_DNRD2 : S_DNCMP;
            end
         end
         S_DNRD2:  state_in = S_DNCMP;
         S_DNCMP:  state_in = cmp_lt ? S_DNRD : S_ROOTRD;
         S_ROOTRD: state_in = S_ROOTWT;
         S_ROOTWT: state_in = S_RESULT;
         S_RESULT: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in  = op_ff;
      sym_in = sym_ff;
      pr_in  = pr_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      cs_in  = cs_ff;
      cp_in  = cp_ff;
      as_in  = as_ff;
      ap_in  = ap_ff;
      st_in  = st_ff;
      vld_in = vld_ff;
      out_in = out_ff;
      hw_we   = 1'b0;
      hw_addr = idx_ff[SymBits-1:0];
      hw_sym  = cs_ff;
      hw_pr   = cp_ff;
      hr_addr = idx_ff[SymBits-1:0];
      t_rd_sym   = sym_ff;
      t_pos_we   = 1'b0;
      t_pos_sym  = cs_ff;
      t_pos_val  = idx_ff[SymBits-1:0];
      t_pres_we  = 1'b0;
      t_pres_sym = sym_ff;
      t_pres_val = 1'b0;
      t_chk_sym  = sym_ff;

      if (vld_ff && rsp_tready) begin
         vld_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            // Keep the root in the read register for a pop.
            hr_addr = '0;
            if (req_tvalid && !vld_ff) begin
               op_in  = op_type'(req_tdata[1:0]);
               sym_in = req_tdata[9:2];
               pr_in  = req_tdata[41:10];
               st_in  = ST_OK;
            end
         end
         S_DECODE: begin
            unique case (op_ff)
               OP_INSERT: begin
                  if (t_present || cnt_ff >= count_type'(SymbolCount)) begin
                     st_in = ST_PRESENT;
                  end else begin
                     idx_in = cnt_ff;
                     cs_in  = sym_ff;
                     cp_in  = pr_ff;
                     hw_we  = 1'b1;
                     hw_addr = cnt_ff[SymBits-1:0];
                     hw_sym = sym_ff;
                     hw_pr  = pr_ff;
                     t_pos_we  = 1'b1;
                     t_pos_sym = sym_ff;
                     t_pos_val = cnt_ff[SymBits-1:0];
                     t_pres_we  = 1'b1;
                     t_pres_val = 1'b1;
                     cnt_in = cnt_ff + count_type'(1);
                  end
               end
               OP_POP: begin
                  if (cnt_ff == '0) begin
                     st_in = ST_EMPTY;
                  end else begin
                     hr_addr = '0;
                  end
               end
               OP_CHANGE: begin
                  if (!t_present) begin
                     st_in = ST_ABSENT;
                  end
               end
               default: begin
               end
            endcase
         end
         S_LOOKUP: begin
            idx_in  = count_type'(t_rd_pos);
            hr_addr = t_rd_pos;
            cs_in   = sym_ff;
            cp_in   = pr_ff;
         end
         S_CHGRD: begin
            if (hr_pr_ff != pr_ff) begin
               hw_we = 1'b1;
               hw_sym = sym_ff;
               hw_pr  = pr_ff;
            end
         end
         S_POPRD: begin
            // hr holds the root; clear its presence, move the last node up.
            t_pres_we  = 1'b1;
            t_pres_sym = hr_sym_ff;
            t_pres_val = 1'b0;
            cnt_in = cnt_ff - count_type'(1);
            hr_addr = cnt_in[SymBits-1:0];
            idx_in = '0;
         end
         S_DNRD: begin
            // The first step of a pop finds the last node in the read register.
            if (op_ff == OP_POP && idx_ff == '0) begin
               cs_in = hr_sym_ff;
               cp_in = hr_pr_ff;
            end
            hr_addr = left_idx[SymBits-1:0];
         end
         S_DNRD2: begin
            as_in   = hr_sym_ff;
            ap_in   = hr_pr_ff;
            hr_addr = right_idx[SymBits-1:0];
         end
         S_DNCMP: begin
            if (cmp_lt) begin
               hw_we   = 1'b1;
               hw_addr = idx_ff[SymBits-1:0];
               hw_sym  = dn_sym;
               hw_pr   = dn_pr;
               t_pos_we  = 1'b1;
               t_pos_sym = dn_sym;
               t_pos_val = idx_ff[SymBits-1:0];
               idx_in = dn_idx;
            end
         end
         S_UPRD: begin
            hr_addr = parent_idx[SymBits-1:0];
         end
         S_UPCMP: begin
            if (cmp_lt) begin
               hw_we  = 1'b1;
               hw_sym = hr_sym_ff;
               hw_pr  = hr_pr_ff;
               t_pos_we  = 1'b1;
               t_pos_sym = hr_sym_ff;
               t_pos_val = idx_ff[SymBits-1:0];
               idx_in = parent_idx;
            end
         end
         S_ROOTRD: begin
            // place the moving node at its final spot
            if (st_ff == ST_OK && (op_ff == OP_INSERT || op_ff == OP_CHANGE ||
                (op_ff == OP_POP && cnt_ff != '0))) begin
               hw_we = 1'b1;
               t_pos_we = 1'b1;
            end
            hr_addr = '0;
         end
         S_ROOTWT: begin
            hr_addr = '0;
         end
         S_RESULT: begin
            vld_in = 1'b1;
            out_in = '0;
            out_in[1:0]   = st_ff;
            out_in[50:42] = cnt_ff;
            if (cnt_ff == '0) begin
               out_in[51] = 1'b1;
            end else begin
               out_in[9:2]   = hr_sym_ff;
               out_in[41:10] = hr_pr_ff;
            end
         end
         default: begin
         end
      endcase

      // pop of the only symbol: clear presence and count at decode.
      if (state_ff == S_DECODE && op_ff == OP_POP && cnt_ff == count_type'(1)) begin
         t_pres_we  = 1'b1;
         t_pres_sym = hr_sym_ff;
         cnt_in = '0;
      end
   end

endmodule

// ----- dv/tb_indexed_min_heap_queue_unit.sv -----
// ---------------------------------------------------------------------------
// tb_indexed_min_heap_queue_unit: self-checking bench of the min-heap queue
// Drives insert, pop, change-priority and no-op requests with random gaps, predicts
// each response with an indexed heap of its own and compares every field.
// ---------------------------------------------------------------------------
module tb_indexed_min_heap_queue_unit
   import imhq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  min_symbol;
      logic [31:0] min_priority;
      logic [8:0]  count;
      logic        is_empty;
   } heap_rsp_type;

   class heap_scoreboard;
      logic [7:0]         node_sym [256];
      logic signed [31:0] node_prio [256];
      int                 pos_of [256];
      bit                 held [256];
      int                 n_held;
      heap_rsp_type       pending_rsp [$];
      int                 n_errors;
      int                 n_checked;
      int                 n_by_status [4];

      function void swap_nodes(int a, int b);
         logic [7:0]         s;
         logic signed [31:0] p;
         s = node_sym[a];
         p = node_prio[a];
         node_sym[a] = node_sym[b];
         node_prio[a] = node_prio[b];
         node_sym[b] = s;
         node_prio[b] = p;
         pos_of[node_sym[a]] = a;
         pos_of[node_sym[b]] = b;
      endfunction

      function void sift_up(int i);
         int parent;
         while (i > 0) begin
            parent = (i - 1) / 2;
            if (node_prio[parent] <= node_prio[i]) break;
            swap_nodes(parent, i);
            i = parent;
         end
      endfunction

      function void sift_down(int i);
         int l;
         int r;
         int pick;
         forever begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (r < n_held) begin
               if (node_prio[i] <= node_prio[l] && node_prio[i] <= node_prio[r]) break;
               pick = (node_prio[l] < node_prio[r]) ? l : r;
            end else if (l < n_held) begin
               if (node_prio[i] <= node_prio[l]) break;
               pick = l;
            end else begin
               break;
            end
            swap_nodes(i, pick);
            i = pick;
         end
      endfunction

      function void note_request(op_type op, logic [7:0] sym, logic signed [31:0] prio);
         heap_rsp_type r;
         status_type   st;
         int           idx;
         st = ST_OK;
         case (op)
            OP_INSERT: begin
               if (held[sym] || n_held >= 256) begin
                  st = ST_PRESENT;
               end else begin
                  idx = n_held;
                  node_sym[idx] = sym;
                  node_prio[idx] = prio;
                  pos_of[sym] = idx;
                  held[sym] = 1;
                  n_held++;
                  sift_up(idx);
               end
            end
            OP_POP: begin
               if (n_held == 0) begin
                  st = ST_EMPTY;
               end else begin
                  held[node_sym[0]] = 0;
                  n_held--;
                  if (n_held > 0) begin
                     node_sym[0] = node_sym[n_held];
                     node_prio[0] = node_prio[n_held];
                     pos_of[node_sym[0]] = 0;
                     sift_down(0);
                  end
               end
            end
            OP_CHANGE: begin
               if (!held[sym]) begin
                  st = ST_ABSENT;
               end else begin
                  idx = pos_of[sym];
                  if (node_prio[idx] < prio) begin
                     node_prio[idx] = prio;
                     sift_down(idx);
                  end else if (node_prio[idx] > prio) begin
                     node_prio[idx] = prio;
                     sift_up(idx);
                  end
               end
            end
            default: ;
         endcase
         r.status = st;
         r.count = 9'(n_held);
         r.is_empty = (n_held == 0);
         r.min_symbol = r.is_empty ? 8'd0 : node_sym[0];
         r.min_priority = r.is_empty ? 32'd0 : node_prio[0];
         pending_rsp = {pending_rsp, r};
         n_by_status[st]++;
      endfunction

      function void check_response(heap_rsp_type got);
         heap_rsp_type want;
         if (pending_rsp.size() == 0) begin
            $error("response with none expected: %h", got);
            n_errors++;
            return;
         end
         want = pending_rsp.pop_front();
         n_checked++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            n_errors++;
         end
         if (got.min_symbol !== want.min_symbol) begin
            $error("min_symbol: expected %0d, actual %0d", want.min_symbol, got.min_symbol);
            n_errors++;
         end
         if (got.min_priority !== want.min_priority) begin
            $error("min_priority: expected %0d, actual %0d",
                   $signed(want.min_priority), $signed(got.min_priority));
            n_errors++;
         end
         if (got.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, got.count);
            n_errors++;
         end
         if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
            n_errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;

   heap_scoreboard board = new();
   bit             calm_phase = 0;
   longint         cycle_count = 0;

   always #2 clock = ~clock;

   indexed_min_heap_queue_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   function automatic heap_rsp_type unpack_rsp(logic [55:0] d);
      heap_rsp_type r;
      r.status = d[1:0];
      r.min_symbol = d[9:2];
      r.min_priority = d[41:10];
      r.count = d[50:42];
      r.is_empty = d[51];
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_response(unpack_rsp(rsp_tdata));
         rsp_tready <= calm_phase || ($urandom_range(99) >= 26);
      end
      if (cycle_count > 400000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_request(op_type op, logic [7:0] sym, logic signed [31:0] prio);
      while (!calm_phase && $urandom_range(99) < 26) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'd0, prio, sym, op};
      do @(posedge clock); while (!req_tready);
      board.note_request(op, sym, prio);
   endtask

   function automatic logic signed [31:0] rand_prio();
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(7)) - 4;
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic logic [7:0] held_or_any();
      logic [7:0] s;
      s = $urandom_range(255);
      if (board.n_held > 0 && $urandom_range(3) != 0) begin
         s = board.node_sym[$urandom_range(board.n_held - 1)];
      end
      return s;
   endfunction

   initial begin
      op_type     op;
      int         pick;
      int         goal;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed opening: corners of every operation.
      send_request(OP_POP, 8'd0, 32'sd0);
      send_request(OP_CHANGE, 8'd5, 32'sd1);
      send_request(OP_INSERT, 8'd0, 32'sh7fffffff);
      send_request(OP_POP, 8'd0, 32'sd0);
      send_request(OP_INSERT, 8'd255, 32'sh7fffffff);
      send_request(OP_INSERT, 8'd0, 32'sh80000000);
      send_request(OP_INSERT, 8'd0, 32'sd3);
      send_request(OP_INSERT, 8'd170, 32'sd5);
      send_request(OP_INSERT, 8'd85, 32'sd5);
      send_request(OP_INSERT, 8'd1, 32'sd5);
      send_request(OP_CHANGE, 8'd170, 32'sd5);
      send_request(OP_CHANGE, 8'd0, 32'sd10);
      send_request(OP_CHANGE, 8'd255, 32'sh80000000);
      send_request(OP_NONE, 8'hff, 32'shffffffff);
      send_request(OP_POP, 8'd0, 32'sd0);
      send_request(OP_POP, 8'd0, 32'sd0);
      send_request(OP_CHANGE, 8'd7, 32'sh5555aaaa);
      // Fill the heap completely, then run random mixes.
      for (int s = 0; s < 256; s++) send_request(OP_INSERT, s[7:0], rand_prio());
      send_request(OP_INSERT, 8'd77, 32'sd0);
      for (int i = 0; i < 700; i++) begin
         calm_phase = (i >= 300 && i < 400);
         pick = $urandom_range(99);
         goal = (i / 100) % 2;
         if (pick < (goal ? 25 : 45)) op = OP_INSERT;
         else if (pick < 70) op = OP_POP;
         else if (pick < 97) op = OP_CHANGE;
         else op = OP_NONE;
         send_request(op, (op == OP_INSERT) ? 8'($urandom_range(255)) : held_or_any(),
                      rand_prio());
      end
      calm_phase = 0;
      while (board.n_held > 0) send_request(OP_POP, 8'($urandom()), $signed($urandom()));
      req_tvalid <= 0;
      while (board.pending_rsp.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Checked %0d responses: %0d ok, %0d duplicate, %0d absent, %0d empty pops.",
               board.n_checked, board.n_by_status[0], board.n_by_status[1],
               board.n_by_status[2], board.n_by_status[3]);
      if (board.n_errors == 0 && board.pending_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
